FILE: rtl/core/lsi_pkg.sv
package lsi_pkg;

  // Fixed field widths
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CHECKIN_W = 2;
  localparam int FLAG_W    = 4;

  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [CHECKIN_W-1:0] chk_t;
  typedef logic [FLAG_W-1:0]    flag_t;

  // Parameter defaults
  localparam int NUM_TASKS_DEF  = 2;
  localparam int TIME_BITS_DEF  = 32;
  localparam int ACCEL_BITS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_NUM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_DEN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE_WIN   = 2'd3;

  // Register reset values
  localparam cfg_t STALE_LIMIT_RST = 16'd100;
  localparam cfg_t TILT_NUM_RST    = 16'd3;
  localparam cfg_t TILT_DEN_RST    = 16'd4;
  localparam cfg_t ALIVE_WIN_RST   = 16'd100;

  // Fault flag bits
  localparam flag_t BIT_STOP   = 4'b0001;
  localparam flag_t BIT_SENSOR = 4'b0010;
  localparam flag_t BIT_TILT   = 4'b0100;
  localparam flag_t BIT_TASK   = 4'b1000;
  localparam flag_t FAULT_RST  = BIT_STOP | BIT_SENSOR;

  // Program steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] ST_EVAL = 4'd1;
  localparam logic [STEP_W-1:0] ST_SQZ  = 4'd2;
  localparam logic [STEP_W-1:0] ST_SQX  = 4'd3;
  localparam logic [STEP_W-1:0] ST_SQY  = 4'd4;
  localparam logic [STEP_W-1:0] ST_LHS  = 4'd5;
  localparam logic [STEP_W-1:0] ST_RHS  = 4'd6;
  localparam logic [STEP_W-1:0] ST_CMP  = 4'd7;
  localparam logic [STEP_W-1:0] ST_FIN  = 4'd8;

  // Multiplier operand selects
  localparam int MUL_W = 3;
  localparam logic [MUL_W-1:0] MUL_NONE = 3'd0;
  localparam logic [MUL_W-1:0] MUL_ZZ   = 3'd1;
  localparam logic [MUL_W-1:0] MUL_XX   = 3'd2;
  localparam logic [MUL_W-1:0] MUL_YY   = 3'd3;
  localparam logic [MUL_W-1:0] MUL_VD   = 3'd4;
  localparam logic [MUL_W-1:0] MUL_AN   = 3'd5;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // Jump conditions
  localparam logic [1:0] JMP_NONE    = 2'd0;
  localparam logic [1:0] JMP_NO_TILT = 2'd1;
  localparam logic [1:0] JMP_ALWAYS  = 2'd2;

  typedef struct packed {
    logic [MUL_W-1:0]  mul_sel;
    logic [1:0]        acc_op;
    logic              ld_vert;
    logic              ld_lhs;
    logic              cmp;
    logic              eval;
    logic              fin;
    logic              wait_in;
    logic [1:0]        jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Control store: one word per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    case (step)
      ST_WAIT: w.wait_in = 1'b1;
      ST_EVAL: begin
        w.eval   = 1'b1;
        w.jmp    = JMP_NO_TILT;
        w.target = ST_FIN;
      end
      ST_SQZ: w.mul_sel = MUL_ZZ;
      ST_SQX: begin
        w.mul_sel = MUL_XX;
        w.acc_op  = ACC_LOAD;
        w.ld_vert = 1'b1;
      end
      ST_SQY: begin
        w.mul_sel = MUL_YY;
        w.acc_op  = ACC_ADD;
      end
      ST_LHS: begin
        w.mul_sel = MUL_VD;
        w.acc_op  = ACC_ADD;
      end
      ST_RHS: begin
        w.mul_sel = MUL_AN;
        w.ld_lhs  = 1'b1;
      end
      ST_CMP: w.cmp = 1'b1;
      ST_FIN: begin
        w.fin    = 1'b1;
        w.jmp    = JMP_ALWAYS;
        w.target = ST_WAIT;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/lsi_tilt_dp.sv
module lsi_tilt_dp #(
  parameter int ACCEL_BITS = lsi_pkg::ACCEL_BITS_DEF
) (
  input  logic                         clk,
  input  lsi_pkg::uword_t              ctl,
  input  logic signed [ACCEL_BITS-1:0] accel_x,
  input  logic signed [ACCEL_BITS-1:0] accel_y,
  input  logic signed [ACCEL_BITS-1:0] accel_z,
  input  lsi_pkg::cfg_t                tilt_num,
  input  lsi_pkg::cfg_t                tilt_den,
  output logic                         ge
);

  localparam int SUM_W  = 2 * ACCEL_BITS;
  localparam int PROD_W = SUM_W + lsi_pkg::CFG_W;

  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [PROD_W-1:0] prod_t;

  logic [ACCEL_BITS-1:0] raw_x, raw_y, raw_z;
  logic [ACCEL_BITS-1:0] mag_x, mag_y, mag_z;
  sum_t                  op_a;
  lsi_pkg::cfg_t         op_b;
  prod_t                 mul_full;
  prod_t                 prod;
  prod_t                 lhs;
  sum_t                  acc;
  sum_t                  vert;

  // Take magnitudes of the axes
  assign raw_x = accel_x;
  assign raw_y = accel_y;
  assign raw_z = accel_z;
  assign mag_x = raw_x[ACCEL_BITS-1] ? -raw_x : raw_x;
  assign mag_y = raw_y[ACCEL_BITS-1] ? -raw_y : raw_y;
  assign mag_z = raw_z[ACCEL_BITS-1] ? -raw_z : raw_z;

  // Select multiplier operands
  always_comb begin
    case (ctl.mul_sel)
      lsi_pkg::MUL_ZZ: begin
        op_a = sum_t'(mag_z);
        op_b = lsi_pkg::cfg_t'(mag_z);
      end
      lsi_pkg::MUL_XX: begin
        op_a = sum_t'(mag_x);
        op_b = lsi_pkg::cfg_t'(mag_x);
      end
      lsi_pkg::MUL_YY: begin
        op_a = sum_t'(mag_y);
        op_b = lsi_pkg::cfg_t'(mag_y);
      end
      lsi_pkg::MUL_VD: begin
        op_a = vert;
        op_b = tilt_den;
      end
      lsi_pkg::MUL_AN: begin
        op_a = acc;
        op_b = tilt_num;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_full = prod_t'(op_a) * prod_t'(op_b);

  // Register the product, then accumulate from the register
  always_ff @(posedge clk) begin
    prod <= mul_full;
    if (ctl.ld_vert) begin
      vert <= prod[SUM_W-1:0];
    end
    if (ctl.ld_lhs) begin
      lhs <= prod;
    end
    case (ctl.acc_op)
      lsi_pkg::ACC_LOAD: acc <= prod[SUM_W-1:0];
      lsi_pkg::ACC_ADD:  acc <= acc + prod[SUM_W-1:0];
      default:           acc <= acc;
    endcase
  end

  // az^2 * den against total * num; prod holds the right side at compare
  assign ge = lhs >= prod;

endmodule

FILE: rtl/core/latched_safety_interlock.sv
// Safety interlock for a small vehicle. Each request is one supervision tick and
// yields one result: the latched fault flags (stop, sensor, tilt, task), a clear to
// run flag, the forced stop, the watchdog refresh and the latest liveness verdict.
// A small control program steps the block through each tick. A tick whose IMU
// sample is fresh and whose vertical axis is positive runs the tilt test on one
// shared 32x16 multiplier that forms five products in turn; any other tick skips
// the test. The next request is taken while the last result still waits; a result
// that is not taken holds the final step until the output register frees. The
// user must write configuration only while the block is idle; the block itself
// does not enforce this.
module latched_safety_interlock #(
  parameter int NUM_TASKS  = lsi_pkg::NUM_TASKS_DEF,
  parameter int TIME_BITS  = lsi_pkg::TIME_BITS_DEF,
  parameter int ACCEL_BITS = lsi_pkg::ACCEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration
  input  logic                            cfg_write,
  input  logic [lsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsi_pkg::CFG_W-1:0]       cfg_data,
  // Tick request
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [TIME_BITS-1:0]            now_ms,
  input  logic [lsi_pkg::CHECKIN_W-1:0]   checkin_bits,
  input  logic                            samples_present,
  input  logic                            range_status_ok,
  input  logic [TIME_BITS-1:0]            range_time_ms,
  input  logic                            imu_status_ok,
  input  logic [TIME_BITS-1:0]            imu_time_ms,
  input  logic signed [ACCEL_BITS-1:0]    accel_x,
  input  logic signed [ACCEL_BITS-1:0]    accel_y,
  input  logic signed [ACCEL_BITS-1:0]    accel_z,
  input  logic                            button_valid,
  input  logic                            button_pressed,
  // Result
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lsi_pkg::FLAG_W-1:0]      fault_flags,
  output logic                            clear_to_run,
  output logic                            emergency_stop,
  output logic                            watchdog_kick,
  output logic                            tasks_ok
);

  typedef logic [TIME_BITS-1:0] time_t;

  localparam int MASK_BITS =
    (NUM_TASKS < lsi_pkg::CHECKIN_W) ? NUM_TASKS : lsi_pkg::CHECKIN_W;
  localparam lsi_pkg::chk_t TASK_MASK = lsi_pkg::chk_t'((1 << MASK_BITS) - 1);
  localparam bit TASKS_COVERED = NUM_TASKS <= lsi_pkg::CHECKIN_W;

  // Configuration registers
  lsi_pkg::cfg_t stale_limit;
  lsi_pkg::cfg_t tilt_num;
  lsi_pkg::cfg_t tilt_den;
  lsi_pkg::cfg_t alive_window;

  // Supervision state
  lsi_pkg::flag_t fault_latch;
  lsi_pkg::chk_t  alive_seen;
  time_t          window_start;
  logic           tasks_alive_flag;
  logic           button_prev;

  // Sequencer
  logic [lsi_pkg::STEP_W-1:0] step;
  logic [lsi_pkg::STEP_W-1:0] step_next;
  lsi_pkg::uword_t            ctl;

  // Held request
  time_t                        held_now;
  lsi_pkg::chk_t                held_checkin;
  logic                         held_present;
  logic                         held_range_stat;
  time_t                        held_range_time;
  logic                         held_imu_ok;
  time_t                        held_imu_time;
  logic signed [ACCEL_BITS-1:0] held_ax;
  logic signed [ACCEL_BITS-1:0] held_ay;
  logic signed [ACCEL_BITS-1:0] held_az;
  logic                         held_btn_valid;
  logic                         held_btn_pressed;

  // Per-tick results
  logic range_pass;
  logic imu_ok;
  logic upright;
  logic kick;

  // Combinational terms
  logic           accept;
  logic           fin_go;
  logic           advance;
  logic           jump;
  lsi_pkg::chk_t  alive_merge;
  logic           all_alive;
  time_t          elapsed;
  time_t          range_age;
  time_t          imu_age;
  logic           window_due;
  logic           range_pass_c;
  logic           imu_ok_c;
  logic           az_pos;
  logic           ge;
  lsi_pkg::flag_t latch_tilt;
  lsi_pkg::flag_t clr_mask;
  logic           press_edge;
  lsi_pkg::flag_t fault_next;

  assign ctl      = lsi_pkg::ucode(step);
  assign in_ready = ctl.wait_in;
  assign accept   = in_valid && in_ready;
  assign fin_go   = ctl.fin && (!out_valid || out_ready);

  // Liveness window and freshness tests
  assign alive_merge = ((held_checkin & ~TASK_MASK) == '0) ? (alive_seen | held_checkin)
                                                          : alive_seen;
  assign all_alive   = TASKS_COVERED && ((alive_merge & TASK_MASK) == TASK_MASK);
  assign elapsed     = held_now - window_start;
  assign window_due  = elapsed >= time_t'(alive_window);
  assign range_age   = held_now - held_range_time;
  assign imu_age     = held_now - held_imu_time;
  assign range_pass_c = held_present && held_range_stat && (range_age <= time_t'(stale_limit));
  assign imu_ok_c    = held_present && held_imu_ok && (imu_age <= time_t'(stale_limit));
  assign az_pos      = !held_az[ACCEL_BITS-1] && (held_az != '0);

  // Step counter with conditional jumps
  always_comb begin
    case (ctl.jmp)
      lsi_pkg::JMP_NO_TILT: jump = !(imu_ok_c && az_pos);
      lsi_pkg::JMP_ALWAYS:  jump = 1'b1;
      default:              jump = 1'b0;
    endcase
    if (ctl.wait_in) begin
      advance = accept;
    end else if (ctl.fin) begin
      advance = fin_go;
    end else begin
      advance = 1'b1;
    end
    if (!advance) begin
      step_next = step;
    end else if (jump) begin
      step_next = ctl.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  // Final latch update with the button edge
  always_comb begin
    latch_tilt = fault_latch | ((imu_ok && !upright) ? lsi_pkg::BIT_TILT : '0);
    clr_mask   = lsi_pkg::BIT_STOP
               | ((range_pass && imu_ok) ? lsi_pkg::BIT_SENSOR : '0)
               | ((imu_ok && upright)   ? lsi_pkg::BIT_TILT   : '0)
               | (tasks_alive_flag      ? lsi_pkg::BIT_TASK   : '0);
    press_edge = held_btn_valid && held_btn_pressed && !button_prev;
    if (!press_edge) begin
      fault_next = latch_tilt;
    end else if (latch_tilt != '0) begin
      fault_next = latch_tilt & ~clr_mask;
    end else begin
      fault_next = latch_tilt | lsi_pkg::BIT_STOP;
    end
  end

  lsi_tilt_dp #(
    .ACCEL_BITS(ACCEL_BITS)
  ) u_tilt (
    .clk      (clk),
    .ctl      (ctl),
    .accel_x  (held_ax),
    .accel_y  (held_ay),
    .accel_z  (held_az),
    .tilt_num (tilt_num),
    .tilt_den (tilt_den),
    .ge       (ge)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit      <= lsi_pkg::STALE_LIMIT_RST;
      tilt_num         <= lsi_pkg::TILT_NUM_RST;
      tilt_den         <= lsi_pkg::TILT_DEN_RST;
      alive_window     <= lsi_pkg::ALIVE_WIN_RST;
      fault_latch      <= lsi_pkg::FAULT_RST;
      alive_seen       <= '0;
      window_start     <= '0;
      tasks_alive_flag <= 1'b0;
      button_prev      <= 1'b1;
      step             <= lsi_pkg::ST_WAIT;
      out_valid        <= 1'b0;
    end else begin
      step <= step_next;

      // Write configuration
      if (cfg_write) begin
        case (cfg_index)
          lsi_pkg::REG_STALE_LIMIT: stale_limit  <= cfg_data;
          lsi_pkg::REG_TILT_NUM:    tilt_num     <= cfg_data;
          lsi_pkg::REG_TILT_DEN:    tilt_den     <= cfg_data;
          lsi_pkg::REG_ALIVE_WIN:   alive_window <= cfg_data;
          default: ;
        endcase
      end

      // Judge liveness and latch sensor and task faults
      if (ctl.eval) begin
        if (window_due) begin
          alive_seen       <= '0;
          window_start     <= held_now;
          tasks_alive_flag <= all_alive;
        end else begin
          alive_seen <= alive_merge;
        end
        fault_latch <= fault_latch
                     | ((window_due && !all_alive)      ? lsi_pkg::BIT_TASK   : '0)
                     | (!(range_pass_c && imu_ok_c)     ? lsi_pkg::BIT_SENSOR : '0);
      end

      // Apply tilt and button, then post the result
      if (fin_go) begin
        fault_latch <= fault_next;
        button_prev <= held_btn_valid ? held_btn_pressed : 1'b1;
        out_valid   <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      held_now         <= now_ms;
      held_checkin     <= checkin_bits;
      held_present     <= samples_present;
      held_range_stat  <= range_status_ok;
      held_range_time  <= range_time_ms;
      held_imu_ok      <= imu_status_ok;
      held_imu_time    <= imu_time_ms;
      held_ax          <= accel_x;
      held_ay          <= accel_y;
      held_az          <= accel_z;
      held_btn_valid   <= button_valid;
      held_btn_pressed <= button_pressed;
    end
    if (ctl.eval) begin
      range_pass <= range_pass_c;
      imu_ok     <= imu_ok_c;
      upright    <= 1'b0;
      kick       <= window_due && all_alive;
    end
    if (ctl.cmp) begin
      upright <= ge;
    end
    // A task fault always leaves a latched bit, so stop follows the flags
    if (fin_go) begin
      fault_flags    <= fault_next;
      clear_to_run   <= fault_next == '0;
      emergency_stop <= fault_next != '0;
      watchdog_kick  <= kick;
      tasks_ok       <= tasks_alive_flag;
    end
  end

  // Checks
  a_clear_matches_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (clear_to_run == (fault_flags == '0)))
    else $error("clear_to_run disagrees with fault_flags");

  a_stop_matches_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (emergency_stop == (fault_flags != '0)))
    else $error("emergency_stop disagrees with fault_flags");

  a_kick_needs_alive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && watchdog_kick) |-> tasks_ok)
    else $error("watchdog refreshed without live tasks");

  a_accept_starts_eval: assert property (@(posedge clk) disable iff (rst)
    accept |=> (step == lsi_pkg::ST_EVAL))
    else $error("accepted request did not start evaluation");

  a_post_from_final: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> ($past(step) == lsi_pkg::ST_FIN))
    else $error("result posted outside the final step");

endmodule
